/* hdl/srld_pkg.sv */
// Shared constants and types of the speech run-length decoder.
package srld_pkg;

  // Tag search window and sample count sizing
  localparam int SEARCH_LIMIT = 100;
  localparam int COUNT_BITS   = 31;
  localparam int SEEN_W       = $clog2(SEARCH_LIMIT + 4);
  localparam int CMP_W        = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Command codes of the stream channel
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Status codes of the result channel
  localparam logic [1:0] ST_SAMPLE  = 2'd0;
  localparam logic [1:0] ST_NO_TAG  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;
  localparam logic [1:0] ST_EARLY   = 2'd3;

  // Item kinds as sorted by the front
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_BYTE = 2'd1;
  localparam logic [1:0] KIND_LAST = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
  } srld_entry_t;

endpackage

/* hdl/srld_if.sv */
// Valid/ready channel interfaces for source items and decoded results.
interface srld_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, command, in_byte, last_byte, input ready);
  modport sink   (input valid, command, in_byte, last_byte, output ready);
endinterface

interface srld_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] sample_raw;
  logic        final_sample;

  modport source (output valid, status, sample_raw, final_sample, input ready);
  modport sink   (input valid, status, sample_raw, final_sample, output ready);
endinterface

/* hdl/srld_front.sv */
// Front end: accepts items, sorts them by kind and queues them for the back end.
module srld_front (
  input  logic                clk,
  input  logic                rst,
  srld_in_if.sink             stream,
  output logic                head_valid,
  output srld_pkg::srld_entry_t head,
  input  logic                head_pop
);
  import srld_pkg::*;

  srld_entry_t       slots [QUEUE_DEPTH];
  srld_entry_t       entry_in;
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // Classify the incoming item
  always_comb begin
    entry_in.data = stream.in_byte;
    if (stream.command == CMD_TICK) begin
      entry_in.kind = KIND_TICK;
    end else if (stream.last_byte) begin
      entry_in.kind = KIND_LAST;
    end else begin
      entry_in.kind = KIND_BYTE;
    end
  end

  assign stream.ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push         = stream.valid && stream.ready;
  assign head_valid   = (count != '0);
  assign pop          = head_pop && head_valid;
  assign head         = slots[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry_in;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");

endmodule

/* hdl/srld_back.sv */
// Back end: decoding state machine, config register and result register.
module srld_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic                  cfg_wdata,
  input  logic                  head_valid,
  input  srld_pkg::srld_entry_t head,
  output logic                  head_pop,
  srld_out_if.source            result
);
  import srld_pkg::*;

  localparam logic [2:0] PH_TAG       = 3'd0;
  localparam logic [2:0] PH_COUNT     = 3'd1;
  localparam logic [2:0] PH_LENGTH    = 3'd2;
  localparam logic [2:0] PH_REPWORD   = 3'd3;
  localparam logic [2:0] PH_LITERAL   = 3'd4;
  localparam logic [2:0] PH_DRAIN     = 3'd5;
  localparam logic [2:0] PH_DRAIN_END = 3'd6;
  localparam logic [2:0] PH_IDLE      = 3'd7;

  localparam logic [31:0] TAG_DATA  = 32'h64617461;
  localparam logic [30:0] COUNT_MAX = 31'((64'd1 << COUNT_BITS) - 64'd1);

  // State registers
  logic                  length_big_endian;
  logic [2:0]            phase, phase_next;
  logic [31:0]           tag_window, tag_window_next;
  logic [SEEN_W-1:0]     bytes_seen, bytes_seen_next;
  logic [COUNT_BITS-1:0] samples_left, samples_left_next;
  logic [7:0]            held_byte, held_byte_next;
  logic                  byte_half, byte_half_next;
  logic [14:0]           literal_left, literal_left_next;
  logic [15:0]           repeat_left, repeat_left_next;
  logic [15:0]           repeat_word, repeat_word_next;

  // Result register
  logic                  out_valid;
  logic [1:0]            out_status;
  logic [15:0]           out_word;
  logic                  out_fin;

  // Working signals
  logic                  pending, is_last, do_clear;
  logic [7:0]            b;
  logic [15:0]           word, len, neg_len;
  logic [31:0]           window_tag, window_cnt;
  logic [SEEN_W-1:0]     seen_inc;
  logic [30:0]           count_word;
  logic [COUNT_BITS-1:0] total_new;
  logic [CMP_W-1:0]      rem_ext, n_ext, len_ext;
  logic [15:0]           rep_min;
  logic [14:0]           lit_min;
  logic                  smp_go, smp_last, smp_fin;
  logic [15:0]           smp_word;
  logic                  res_valid, res_fin;
  logic [1:0]            res_status;
  logic [15:0]           res_word;

  assign head_pop = head_valid && (!out_valid || result.ready);

  // Datapath pieces shared by the phases
  always_comb begin
    b          = head.data;
    is_last    = (head.kind == KIND_LAST);
    pending    = (phase == PH_DRAIN || phase == PH_DRAIN_END) && (repeat_left != '0);
    word       = {b, held_byte};
    len        = length_big_endian ? {held_byte, b} : word;
    neg_len    = 16'(~len + 16'd1);
    window_tag = {tag_window[23:0], b};
    window_cnt = {b, tag_window[31:8]};
    seen_inc   = bytes_seen + 1'b1;
    count_word = window_cnt[31:1];
    total_new  = (count_word > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX)
                                          : COUNT_BITS'(count_word);
    rem_ext    = CMP_W'(samples_left);
    n_ext      = CMP_W'(neg_len);
    len_ext    = CMP_W'(len[14:0]);
    rep_min    = 16'((n_ext > rem_ext) ? rem_ext : n_ext);
    lit_min    = 15'((len_ext > rem_ext) ? rem_ext : len_ext);
  end

  // Decoder next state and result
  always_comb begin
    phase_next        = phase;
    tag_window_next   = tag_window;
    bytes_seen_next   = bytes_seen;
    samples_left_next = samples_left;
    held_byte_next    = held_byte;
    byte_half_next    = byte_half;
    literal_left_next = literal_left;
    repeat_left_next  = repeat_left;
    repeat_word_next  = repeat_word;
    do_clear   = 1'b0;
    smp_go     = 1'b0;
    smp_last   = 1'b0;
    smp_fin    = 1'b0;
    smp_word   = '0;
    res_valid  = 1'b0;
    res_status = ST_SAMPLE;
    res_word   = '0;
    res_fin    = 1'b0;

    if (head_pop) begin
      if (head.kind == KIND_TICK) begin
        // Drain tick: one more copy of the pending repeat
        if (pending) begin
          repeat_left_next = repeat_left - 1'b1;
          if (repeat_left == 16'd1) begin
            phase_next = PH_LENGTH;
            smp_go     = 1'b1;
            smp_word   = repeat_word;
            smp_last   = (phase == PH_DRAIN_END);
          end else begin
            samples_left_next = samples_left - 1'b1;
            res_valid         = 1'b1;
            res_word          = repeat_word;
          end
        end
      end else if (pending) begin
        // Byte while a repeat is open is refused
        res_valid  = 1'b1;
        res_status = ST_REFUSED;
      end else begin
        case (phase)
          PH_IDLE: begin
            if (is_last) begin
              do_clear = 1'b1;
            end
          end
          PH_TAG: begin
            tag_window_next = window_tag;
            bytes_seen_next = seen_inc;
            if (seen_inc >= SEEN_W'(4) && window_tag == TAG_DATA) begin
              if (is_last) begin
                do_clear   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_EARLY;
              end else begin
                phase_next      = PH_COUNT;
                tag_window_next = '0;
                bytes_seen_next = '0;
              end
            end else if (is_last) begin
              do_clear   = 1'b1;
              res_valid  = 1'b1;
              res_status = ST_NO_TAG;
            end else if (seen_inc >= SEEN_W'(SEARCH_LIMIT + 3)) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res_status = ST_NO_TAG;
            end
          end
          PH_COUNT: begin
            tag_window_next = window_cnt;
            bytes_seen_next = seen_inc;
            if (seen_inc != SEEN_W'(4)) begin
              if (is_last) begin
                do_clear   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_EARLY;
              end
            end else begin
              samples_left_next = total_new;
              if (total_new == '0) begin
                if (is_last) begin
                  do_clear = 1'b1;
                end else begin
                  phase_next = PH_IDLE;
                end
              end else if (is_last) begin
                do_clear   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_EARLY;
              end else begin
                phase_next = PH_LENGTH;
              end
            end
          end
          default: begin
            // Word phases: collect two bytes, then act on the word
            if (!byte_half) begin
              held_byte_next = b;
              byte_half_next = 1'b1;
              if (is_last) begin
                do_clear   = 1'b1;
                res_valid  = 1'b1;
                res_status = ST_EARLY;
              end
            end else begin
              byte_half_next = 1'b0;
              case (phase)
                PH_LENGTH: begin
                  if (len[15]) begin
                    repeat_left_next = rep_min;
                    phase_next       = PH_REPWORD;
                  end else if (len != '0) begin
                    literal_left_next = lit_min;
                    phase_next        = PH_LITERAL;
                  end
                  if (is_last) begin
                    do_clear   = 1'b1;
                    res_valid  = 1'b1;
                    res_status = ST_EARLY;
                  end
                end
                PH_REPWORD: begin
                  repeat_word_next = word;
                  repeat_left_next = repeat_left - 1'b1;
                  if (repeat_left == 16'd1) begin
                    phase_next = PH_LENGTH;
                    smp_go     = 1'b1;
                    smp_word   = word;
                    smp_last   = is_last;
                  end else begin
                    phase_next        = is_last ? PH_DRAIN_END : PH_DRAIN;
                    samples_left_next = samples_left - 1'b1;
                    res_valid         = 1'b1;
                    res_word          = word;
                  end
                end
                default: begin
                  // literal word
                  literal_left_next = literal_left - 1'b1;
                  if (literal_left == 15'd1) begin
                    phase_next = PH_LENGTH;
                  end
                  smp_go   = 1'b1;
                  smp_word = word;
                  smp_last = is_last;
                end
              endcase
            end
          end
        endcase
      end
    end

    // Sample that may complete the count or the file
    if (smp_go) begin
      samples_left_next = samples_left - 1'b1;
      smp_fin           = (samples_left == COUNT_BITS'(1));
      res_valid         = 1'b1;
      res_word          = smp_word;
      res_fin           = smp_fin;
      if (smp_last) begin
        do_clear   = 1'b1;
        res_status = smp_fin ? ST_SAMPLE : ST_EARLY;
      end else if (smp_fin) begin
        phase_next = PH_IDLE;
      end
    end

    // End of file: back to tag search
    if (do_clear) begin
      phase_next        = PH_TAG;
      tag_window_next   = '0;
      bytes_seen_next   = '0;
      samples_left_next = '0;
      held_byte_next    = '0;
      byte_half_next    = 1'b0;
      literal_left_next = '0;
      repeat_left_next  = '0;
      repeat_word_next  = '0;
    end
  end

  // State and config register
  always_ff @(posedge clk) begin
    if (rst) begin
      length_big_endian <= 1'b0;
      phase             <= PH_TAG;
      tag_window        <= '0;
      bytes_seen        <= '0;
      samples_left      <= '0;
      held_byte         <= '0;
      byte_half         <= 1'b0;
      literal_left      <= '0;
      repeat_left       <= '0;
      repeat_word       <= '0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        length_big_endian <= cfg_wdata;
      end
      phase        <= phase_next;
      tag_window   <= tag_window_next;
      bytes_seen   <= bytes_seen_next;
      samples_left <= samples_left_next;
      held_byte    <= held_byte_next;
      byte_half    <= byte_half_next;
      literal_left <= literal_left_next;
      repeat_left  <= repeat_left_next;
      repeat_word  <= repeat_word_next;
      if (head_pop && res_valid) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (head_pop && res_valid) begin
      out_status <= res_status;
      out_word   <= res_word;
      out_fin    <= res_fin;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.sample_raw   = out_word;
  assign result.final_sample = out_fin;

  a_fin_is_sample: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.final_sample |-> result.status == ST_SAMPLE)
    else $error("final sample flagged on a non-sample result");

  a_drain_has_work: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DRAIN || phase == PH_DRAIN_END) |-> repeat_left != '0)
    else $error("drain phase with no repeat left");

  a_half_in_words: assert property (@(posedge clk) disable iff (rst)
    byte_half |-> (phase == PH_LENGTH || phase == PH_REPWORD || phase == PH_LITERAL))
    else $error("held byte outside word phases");

  a_samples_open: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LENGTH || phase == PH_REPWORD || phase == PH_LITERAL ||
     phase == PH_DRAIN || phase == PH_DRAIN_END) |-> samples_left != '0)
    else $error("decoding words with the sample count already reached");

endmodule

/* hdl/speech_run_length_decoder_unit.sv */
// Top level of the speech run-length decoder.
//
//   channel    dir  handshake      payload
//   stream     in   valid/ready    command, in_byte, last_byte
//   result     out  valid/ready    status, sample_raw, final_sample
//   cfg        in   cfg_we         cfg_wdata (length_big_endian)
//
// One item per cycle while the sink keeps up; results are registered.
// A four-entry queue parts the front from the decoder, and a result register parts
// the decoder from the sink, so each side stalls on its own.
// Reset is synchronous; there is no clearing pass.
// The decoder state machine takes one queued item per cycle whenever the result
// register is empty or being taken.
module speech_run_length_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  srld_in_if.sink    stream,
  srld_out_if.source result
);
  import srld_pkg::*;

  srld_entry_t head;
  logic        head_valid;
  logic        head_pop;

  srld_front u_front (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  srld_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .result     (result)
  );

endmodule

/* sim/speech_run_length_decoder_unit_tb.sv */
// Self-checking testbench for the speech run-length decoder: directed table, then random files.
module speech_run_length_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srld_pkg::*;

  localparam logic [31:0] DATA_TAG     = 32'h64617461;
  localparam int unsigned COUNT_MAX    = (1 << COUNT_BITS) - 1;
  localparam int          ITEMS_TOTAL  = 1550;
  localparam int          RAND_PHASES  = 4;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          LONG_HOLD    = 80;
  localparam int          STALL_LIMIT  = 2000;
  localparam int          EXP_DEPTH    = 64;
  localparam int          FILE_DEPTH   = 1024;

  typedef enum logic [2:0] {
    ST_TAG, ST_COUNT, ST_LENGTH, ST_REP_WORD, ST_LITERAL, ST_DRAIN, ST_DRAIN_END, ST_IDLE
  } dec_state_e;

  typedef struct packed {
    logic       command;
    logic [7:0] in_byte;
    logic       last_byte;
  } src_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] sample_raw;
    logic        final_sample;
  } dec_result_t;

  // One directed transfer; the expectation is used only where typed is set
  typedef struct packed {
    logic        command;
    logic [7:0]  in_byte;
    logic        last_byte;
    logic        typed;
    logic        has_res;
    logic [1:0]  status;
    logic [15:0] sample_raw;
    logic        final_sample;
  } directed_row_t;

  localparam directed_row_t DIRECTED [25] = '{
    // lone byte ending the file during tag search
    '{CMD_BYTE, 8'h64, 1'b1, 1'b1, 1'b1, ST_NO_TAG,  16'h0000, 1'b0},
    // tick with nothing pending
    '{CMD_TICK, 8'hFF, 1'b1, 1'b1, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h64, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h61, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h74, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h61, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    // all-ones byte count, gives the largest sample count
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    // zero length word
    '{CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    // repeat of three, word 0x1234
    '{CMD_BYTE, 8'hFD, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h34, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h12, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    // byte while the repeat is pending, marked last but still refused
    '{CMD_BYTE, 8'hAA, 1'b1, 1'b1, 1'b1, ST_REFUSED, 16'h0000, 1'b0},
    '{CMD_TICK, 8'h00, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_TICK, 8'h00, 1'b1, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    // literal of two words, file cut after the second
    '{CMD_BYTE, 8'h02, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h01, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'h00, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b0, 1'b0, 1'b0, ST_SAMPLE,  16'h0000, 1'b0},
    '{CMD_BYTE, 8'hFF, 1'b1, 1'b1, 1'b1, ST_EARLY,   16'hFFFF, 1'b0}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  srld_in_if  stream_if ();
  srld_out_if result_if ();

  speech_run_length_decoder_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .stream    (stream_if),
    .result    (result_if)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Decoder state mirror
  dec_state_e             dec_state;
  logic [31:0]            tag_shift;
  logic [6:0]             seen_cnt;
  logic [COUNT_BITS-1:0]  samples_total;
  logic [COUNT_BITS-1:0]  samples_done;
  logic [7:0]             low_byte;
  logic                   have_low;
  logic [14:0]            literal_cnt;
  logic [15:0]            repeat_cnt;
  logic [15:0]            repeat_val;
  logic                   len_big_endian;

  // Expected results in order (ring), and the file being built
  dec_result_t exp_mem [EXP_DEPTH];
  int          exp_head = 0;
  int          exp_tail = 0;
  src_item_t   file_mem [FILE_DEPTH];
  int          file_len = 0;
  int          error_count = 0;
  int          fed_items = 0;
  bit          steady_mode = 1'b0;
  bit          long_hold_armed = 1'b0;
  bit          long_hold_done = 1'b0;

  function automatic void reset_decoder();
    dec_state     = ST_TAG;
    tag_shift     = '0;
    seen_cnt      = '0;
    samples_total = '0;
    samples_done  = '0;
    low_byte      = '0;
    have_low      = 1'b0;
    literal_cnt   = '0;
    repeat_cnt    = '0;
    repeat_val    = '0;
  endfunction

  function automatic void push_result(logic [1:0] st, logic [15:0] w, logic fin);
    dec_result_t r;
    r.status       = st;
    r.sample_raw   = w;
    r.final_sample = fin;
    exp_mem[exp_tail % EXP_DEPTH] = r;
    exp_tail++;
  endfunction

  function automatic bit drain_pending();
    return (dec_state == ST_DRAIN || dec_state == ST_DRAIN_END) && repeat_cnt != 0;
  endfunction

  // One sample out; a last byte closes the file, short of the count it is an early end
  function automatic void give_sample(logic [15:0] w, bit last);
    logic fin;
    samples_done = samples_done + 1'b1;
    fin = (samples_done >= samples_total);
    if (last) begin
      reset_decoder();
      push_result(fin ? ST_SAMPLE : ST_EARLY, w, fin);
    end else begin
      if (fin) dec_state = ST_IDLE;
      push_result(ST_SAMPLE, w, fin);
    end
  endfunction

  // Expected results of one accepted transfer
  function automatic void decode_item(src_item_t it);
    bit          end_mode;
    logic [15:0] word;
    logic [15:0] len;
    int unsigned rem;
    int unsigned n;
    int unsigned cnt;
    logic [7:0]  b;
    b = it.in_byte;
    if (it.command == CMD_TICK) begin
      if (drain_pending()) begin
        end_mode = (dec_state == ST_DRAIN_END);
        repeat_cnt = repeat_cnt - 1'b1;
        if (repeat_cnt == 0) begin
          dec_state = ST_LENGTH;
          give_sample(repeat_val, end_mode);
        end else begin
          samples_done = samples_done + 1'b1;
          push_result(ST_SAMPLE, repeat_val, 1'b0);
        end
      end
      return;
    end
    if (drain_pending()) begin
      push_result(ST_REFUSED, 16'h0000, 1'b0);
      return;
    end
    case (dec_state)
      ST_IDLE: begin
        if (it.last_byte) reset_decoder();
      end
      ST_TAG: begin
        tag_shift = {tag_shift[23:0], b};
        seen_cnt = seen_cnt + 1'b1;
        if (seen_cnt >= 4 && tag_shift == DATA_TAG) begin
          if (it.last_byte) begin
            reset_decoder();
            push_result(ST_EARLY, 16'h0000, 1'b0);
          end else begin
            dec_state = ST_COUNT;
            tag_shift = '0;
            seen_cnt = '0;
          end
        end else if (it.last_byte) begin
          reset_decoder();
          push_result(ST_NO_TAG, 16'h0000, 1'b0);
        end else if (int'(seen_cnt) >= SEARCH_LIMIT + 3) begin
          dec_state = ST_IDLE;
          push_result(ST_NO_TAG, 16'h0000, 1'b0);
        end
      end
      ST_COUNT: begin
        tag_shift[8*seen_cnt[1:0] +: 8] = b;
        seen_cnt = seen_cnt + 1'b1;
        if (seen_cnt < 4) begin
          if (it.last_byte) begin
            reset_decoder();
            push_result(ST_EARLY, 16'h0000, 1'b0);
          end
        end else begin
          cnt = tag_shift >> 1;
          samples_total = (cnt > COUNT_MAX) ? COUNT_BITS'(COUNT_MAX) : COUNT_BITS'(cnt);
          samples_done = '0;
          if (samples_total == 0) begin
            if (it.last_byte) reset_decoder();
            else dec_state = ST_IDLE;
          end else if (it.last_byte) begin
            reset_decoder();
            push_result(ST_EARLY, 16'h0000, 1'b0);
          end else begin
            dec_state = ST_LENGTH;
          end
        end
      end
      default: begin
        // word phases: length, repeated word, literal
        if (!have_low) begin
          low_byte = b;
          have_low = 1'b1;
          if (it.last_byte) begin
            reset_decoder();
            push_result(ST_EARLY, 16'h0000, 1'b0);
          end
          return;
        end
        have_low = 1'b0;
        word = {b, low_byte};
        rem = int'(samples_total) - int'(samples_done);
        if (dec_state == ST_LENGTH) begin
          len = len_big_endian ? {low_byte, b} : word;
          if (len[15]) begin
            n = 32'h10000 - len;
            repeat_cnt = (n > rem) ? 16'(rem) : 16'(n);
            dec_state = ST_REP_WORD;
          end else if (len != 0) begin
            literal_cnt = (len > rem) ? 15'(rem) : len[14:0];
            dec_state = ST_LITERAL;
          end
          if (it.last_byte) begin
            reset_decoder();
            push_result(ST_EARLY, 16'h0000, 1'b0);
          end
        end else if (dec_state == ST_REP_WORD) begin
          repeat_val = word;
          repeat_cnt = repeat_cnt - 1'b1;
          if (repeat_cnt == 0) begin
            dec_state = ST_LENGTH;
            give_sample(word, it.last_byte);
          end else begin
            dec_state = it.last_byte ? ST_DRAIN_END : ST_DRAIN;
            samples_done = samples_done + 1'b1;
            push_result(ST_SAMPLE, word, 1'b0);
          end
        end else begin
          literal_cnt = literal_cnt - 1'b1;
          if (literal_cnt == 0) dec_state = ST_LENGTH;
          give_sample(word, it.last_byte);
        end
      end
    endcase
  endfunction

  // File builder helpers
  function automatic void file_put(src_item_t it);
    if (file_len < FILE_DEPTH) begin
      file_mem[file_len] = it;
      file_len++;
    end
  endfunction

  function automatic void add_item(logic cmd, logic [7:0] b);
    src_item_t it;
    it.command   = cmd;
    it.in_byte   = b;
    it.last_byte = 1'b0;
    file_put(it);
  endfunction

  function automatic void add_word(logic [15:0] w, bit msb_first);
    add_item(CMD_BYTE, msb_first ? w[15:8] : w[7:0]);
    add_item(CMD_BYTE, msb_first ? w[7:0] : w[15:8]);
  endfunction

  // Mostly well-formed files with random content, some noise, some cut short
  function automatic void build_file();
    int unsigned style, junk, samples, planned, n, runs, i, copies, cut;
    bit          huge;
    logic [31:0] byte_cnt;
    src_item_t   it;
    file_len = 0;
    style = $urandom_range(0, 99);
    if (style < 4) begin
      repeat ($urandom_range(5, 40)) begin
        it.command   = 1'($urandom_range(0, 1));
        it.in_byte   = 8'($urandom);
        it.last_byte = ($urandom_range(0, 9) == 0);
        file_put(it);
      end
    end else begin
      // long junk puts the tag start around the search window edge
      junk = (style < 9) ? $urandom_range(94, 108) : $urandom_range(0, 5);
      repeat (junk) add_item(CMD_BYTE, 8'($urandom));
      if (style < 9 || style >= 12) begin
        add_item(CMD_BYTE, DATA_TAG[31:24]);
        add_item(CMD_BYTE, DATA_TAG[23:16]);
        add_item(CMD_BYTE, DATA_TAG[15:8]);
        add_item(CMD_BYTE, DATA_TAG[7:0]);
      end
      n = $urandom_range(0, 99);
      huge = (n < 6);
      if (huge) samples = 30;
      else if (n < 14) samples = 0;
      else if (n < 24) samples = $urandom_range(25, 60);
      else samples = $urandom_range(1, 24);
      if (huge) byte_cnt = $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
      else byte_cnt = samples * 2 + $urandom_range(0, 1);
      for (i = 0; i < 4; i++) add_item(CMD_BYTE, byte_cnt[8*i +: 8]);
      planned = 0;
      runs = 0;
      while (planned < samples && runs < 40) begin
        runs++;
        n = $urandom_range(0, 19);
        if (n == 0) begin
          add_word(16'h0000, len_big_endian);
        end else if (n < 10) begin
          n = (!huge && $urandom_range(0, 11) == 0) ? 32768 : $urandom_range(1, 10);
          add_word(16'(32'h10000 - n), len_big_endian);
          add_word(16'($urandom), 1'b0);
          copies = (huge || n < samples - planned) ? n : samples - planned;
          for (i = 1; i < copies; i++) begin
            if ($urandom_range(0, 24) == 0) add_item(CMD_BYTE, 8'($urandom));
            add_item(CMD_TICK, 8'($urandom));
          end
          planned += n;
        end else begin
          n = $urandom_range(1, 8);
          add_word(16'(n), len_big_endian);
          repeat (n) add_word(16'($urandom), 1'b0);
          if ($urandom_range(0, 9) == 0) add_item(CMD_TICK, 8'($urandom));
          planned += n;
        end
      end
      repeat ($urandom_range(0, 3)) add_item(CMD_BYTE, 8'($urandom));
      if ($urandom_range(0, 4) == 0) begin
        cut = $urandom_range(0, file_len - 1);
        file_len = int'(cut) + 1;
      end
    end
    // the file closes on a byte marked last
    while (file_len > 0 && file_mem[file_len-1].command == CMD_TICK) file_len--;
    if (file_len == 0) add_item(CMD_BYTE, 8'($urandom));
    file_mem[file_len-1].last_byte = 1'b1;
  endfunction

  // Drive one item and wait for its transfer
  task automatic send_item(src_item_t it);
    if (!steady_mode && $urandom_range(0, 7) == 0) begin
      stream_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    stream_if.valid     <= 1'b1;
    stream_if.command   <= it.command;
    stream_if.in_byte   <= it.in_byte;
    stream_if.last_byte <= it.last_byte;
    do @(posedge clk); while (!stream_if.ready);
  endtask

  task automatic feed(src_item_t it);
    bit ignored;
    send_item(it);
    ignored = it.command == CMD_TICK ? !drain_pending()
            : (!drain_pending() && dec_state == ST_IDLE && !it.last_byte);
    if (!ignored) fed_items++;
    decode_item(it);
  endtask

  // Drain any pending repeat and close the file so the next one starts clean
  task automatic close_file();
    src_item_t it;
    while (dec_state != ST_TAG || drain_pending()) begin
      it.command   = drain_pending() ? CMD_TICK : CMD_BYTE;
      it.in_byte   = 8'($urandom);
      it.last_byte = 1'b1;
      feed(it);
    end
  endtask

  // Sender pause until every expected result is back, then a quiet settling pause
  task automatic settle();
    stream_if.valid <= 1'b0;
    while (exp_tail != exp_head) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length_order(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    len_big_endian = v;
  endtask

  // Result side: compare each transfer, random ready bursts, one long hold-off
  initial begin : result_sink
    int          hold_left;
    dec_result_t want;
    hold_left = 0;
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result_if.valid && result_if.ready) begin
        if (exp_tail == exp_head) begin
          $error("unexpected result: status %0d sample_raw %h final_sample %0d",
                 result_if.status, result_if.sample_raw, result_if.final_sample);
          error_count++;
        end else begin
          want = exp_mem[exp_head % EXP_DEPTH];
          exp_head++;
          if (result_if.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_if.status);
            error_count++;
          end
          if (result_if.sample_raw !== want.sample_raw) begin
            $error("sample_raw: expected %h, got %h", want.sample_raw, result_if.sample_raw);
            error_count++;
          end
          if (result_if.final_sample !== want.final_sample) begin
            $error("final_sample: expected %0d, got %0d",
                   want.final_sample, result_if.final_sample);
            error_count++;
          end
        end
      end
      if (long_hold_armed && !long_hold_done) begin
        hold_left = LONG_HOLD;
        long_hold_done = 1'b1;
      end else if (hold_left == 0 && !steady_mode && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(1, 12);
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transfer
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if (rst || (stream_if.valid && stream_if.ready) || (result_if.valid && result_if.ready))
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin : stimulus
    int        r, ph, n0, budget, k;
    src_item_t it;
    stream_if.valid     <= 1'b0;
    stream_if.command   <= CMD_BYTE;
    stream_if.in_byte   <= 8'h00;
    stream_if.last_byte <= 1'b0;
    len_big_endian = 1'b0;
    reset_decoder();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table, length words little endian after reset
    for (r = 0; r < $size(DIRECTED); r++) begin
      it.command   = DIRECTED[r].command;
      it.in_byte   = DIRECTED[r].in_byte;
      it.last_byte = DIRECTED[r].last_byte;
      send_item(it);
      n0 = exp_tail;
      decode_item(it);
      if (DIRECTED[r].typed) begin
        exp_tail = n0;
        if (DIRECTED[r].has_res)
          push_result(DIRECTED[r].status, DIRECTED[r].sample_raw, DIRECTED[r].final_sample);
      end
    end
    close_file();
    settle();

    // random files over both length byte orders; last phase runs without idling
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      write_length_order(ph == RAND_PHASES - 1 ? 1'($urandom_range(0, 1)) : 1'(~ph[0]));
      if (ph == 1) long_hold_armed = 1'b1;
      if (ph == RAND_PHASES - 1) steady_mode = 1'b1;
      budget = (ph + 1) * ITEMS_TOTAL / RAND_PHASES;
      while (fed_items < budget) begin
        build_file();
        for (k = 0; k < file_len; k++) feed(file_mem[k]);
        close_file();
      end
      settle();
    end

    if (error_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
